@@ src/fbp_pkg.sv @@
// Shared types, sizes and codes for the float box placement table.
// No dependencies; every other file imports this package.
package fbp_pkg;

	localparam int MAX_FLOATS = 16;
	localparam int IDX_W      = (MAX_FLOATS > 1) ? $clog2(MAX_FLOATS) : 1;
	localparam int CNT_W      = $clog2(MAX_FLOATS + 1);
	localparam int PASS_MAX   = 2 * MAX_FLOATS + 2;
	localparam int PASS_W     = $clog2(PASS_MAX);
	localparam int CW         = 20;

	localparam logic [2:0] MODE_LEFT  = 3'd0;
	localparam logic [2:0] MODE_RIGHT = 3'd1;
	localparam logic [2:0] MODE_SHRNK = 3'd2;
	localparam logic [2:0] MODE_LINE  = 3'd3;
	localparam logic [2:0] MODE_CLEAR = 3'd4;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [15:0]   c16_t;

	typedef struct packed {
		coord_t l;
		coord_t t;
		coord_t r;
		coord_t b;
	} rect_t;

	typedef struct packed {
		c16_t l;
		c16_t t;
		c16_t r;
		c16_t b;
	} rect16_t;

	typedef struct packed {
		logic [2:0]  mode;
		c16_t        box_left;
		c16_t        box_top;
		c16_t        box_right;
		c16_t        box_bottom;
		logic [14:0] container_width;
		logic [14:0] line_height;
		logic [14:0] min_width;
	} in_item_t;

	typedef struct packed {
		c16_t        out_left;
		c16_t        out_top;
		c16_t        out_right;
		c16_t        out_bottom;
		logic [14:0] left_clear;
		logic [14:0] right_clear;
		logic        store_full;
	} out_item_t;

	typedef struct packed {
		logic             load;
		logic             scan_step;
		logic             eval;
		logic             commit;
		logic [IDX_W-1:0] idx;
	} ctl_cmd_t;

	typedef struct packed {
		logic search_mode;
		logic done;
		logic out_free;
	} dp_status_t;

	function automatic rect_t ext16(rect16_t v);
		rect_t res;
		res.l = CW'(v.l);
		res.t = CW'(v.t);
		res.r = CW'(v.r);
		res.b = CW'(v.b);
		return res;
	endfunction

	function automatic coord_t cmax(coord_t a, coord_t b);
		return (a > b) ? a : b;
	endfunction

	function automatic coord_t cmin(coord_t a, coord_t b);
		return (a < b) ? a : b;
	endfunction

endpackage

@@ src/fbp_if.sv @@
// Channel interfaces for the float box placement table: input and result items.
// Depends on fbp_pkg for field types.
interface fbp_in_if import fbp_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	c16_t        box_left;
	c16_t        box_top;
	c16_t        box_right;
	c16_t        box_bottom;
	logic [14:0] container_width;
	logic [14:0] line_height;
	logic [14:0] min_width;

	modport source(output valid, mode, box_left, box_top, box_right, box_bottom,
		container_width, line_height, min_width, input ready);
	modport sink(input valid, mode, box_left, box_top, box_right, box_bottom,
		container_width, line_height, min_width, output ready);
endinterface

interface fbp_out_if import fbp_pkg::*; ();
	logic        valid;
	logic        ready;
	c16_t        out_left;
	c16_t        out_top;
	c16_t        out_right;
	c16_t        out_bottom;
	logic [14:0] left_clear;
	logic [14:0] right_clear;
	logic        store_full;

	modport source(output valid, out_left, out_top, out_right, out_bottom,
		left_clear, right_clear, store_full, input ready);
	modport sink(input valid, out_left, out_top, out_right, out_bottom,
		left_clear, right_clear, store_full, output ready);
endinterface

@@ src/fbp_ctrl.sv @@
// Controller for the float box placement table: sequences scan passes and eval.
// Depends on fbp_pkg.
module fbp_ctrl import fbp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output ctl_cmd_t   cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_EVAL  = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]        state_q, state_nx;
	logic [IDX_W-1:0]  idx_q, idx_nx;
	logic [PASS_W-1:0] pass_q, pass_nx;

	always_comb begin
		state_nx      = state_q;
		idx_nx        = idx_q;
		pass_nx       = pass_q;
		in_ready      = 1'b0;
		cmd.load      = 1'b0;
		cmd.scan_step = 1'b0;
		cmd.eval      = 1'b0;
		cmd.commit    = 1'b0;
		cmd.idx       = idx_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					idx_nx   = '0;
					pass_nx  = '0;
					state_nx = status.search_mode ? S_SCAN : S_DONE;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				idx_nx        = idx_q + 1'b1;
				if (idx_q == IDX_W'(MAX_FLOATS - 1)) begin
					state_nx = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_nx = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				if (status.done || pass_q == PASS_W'(PASS_MAX - 1)) begin
					state_nx = S_DONE;
				end else begin
					pass_nx  = pass_q + 1'b1;
					idx_nx   = '0;
					state_nx = S_SCAN;
				end
			end
			S_DONE: begin
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_nx   = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			pass_q  <= '0;
		end else begin
			state_q <= state_nx;
			idx_q   <= idx_nx;
			pass_q  <= pass_nx;
		end
	end

endmodule

@@ src/fbp_dp.sv @@
// Datapath for the float box placement table: float stores, scan, box update.
// Depends on fbp_pkg; driven by fbp_ctrl commands.
module fbp_dp import fbp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  in_item_t   in_item,
	input  ctl_cmd_t   cmd,
	output dp_status_t status,
	output out_item_t  out_item,
	output logic       out_valid,
	input  logic       out_ready
);

	rect16_t left_rects[MAX_FLOATS];
	rect16_t right_rects[MAX_FLOATS];
	logic [CNT_W-1:0] left_cnt_q, right_cnt_q;
	logic [14:0] lc_q, rc_q;
	logic out_valid_q;

	logic [2:0]  mode_q;
	rect_t       box_q, lb_q, rb_q;
	coord_t      lim_q;
	logic [14:0] h_q, minw_q;

	rect16_t lrd_s1, rrd_s1;
	logic    lval_s1, rval_s1;

	// load values
	rect_t  ld_box;
	coord_t ld_lim;
	always_comb begin
		ld_box.l = CW'(in_item.box_left);
		ld_box.t = CW'(in_item.box_top);
		ld_box.r = CW'(in_item.box_right);
		ld_box.b = (in_item.mode == MODE_LINE) ?
			CW'(in_item.box_top) + CW'({1'b0, in_item.line_height}) :
			CW'(in_item.box_bottom);
		ld_lim = (in_item.mode == MODE_LINE) ? CW'(in_item.box_right) :
			CW'({1'b0, in_item.container_width});
	end

	// scan accumulation
	rect_t lf, rf;
	logic  l_take, r_take;
	always_comb begin
		lf     = ext16(lrd_s1);
		rf     = ext16(rrd_s1);
		l_take = lval_s1 && (cmin(lf.b, box_q.b) > cmax(lf.t, box_q.t)) && (lb_q.r < lf.r);
		r_take = rval_s1 && (cmin(rf.b, box_q.b) > cmax(rf.t, box_q.t)) && (rb_q.l > rf.l);
	end

	// pass evaluation
	logic   ln, rn, to_right, is_line, fit, lfit, done;
	coord_t offl, offr, newt, ll, lr, lt;
	rect_t  ev_box;
	always_comb begin
		ln       = (lb_q.l == lb_q.r) || (lb_q.t == lb_q.b);
		rn       = (rb_q.l == rb_q.r) || (rb_q.t == rb_q.b);
		to_right = (mode_q == MODE_RIGHT);
		is_line  = (mode_q == MODE_LINE);
		offl     = box_q.l;
		offr     = box_q.r;
		if (!to_right) begin
			if (box_q.l < lb_q.r) begin
				offl = lb_q.r;
				offr = box_q.r + (lb_q.r - box_q.l);
			end
			fit = (offr <= rb_q.l);
		end else begin
			if (box_q.r > rb_q.l) begin
				offr = rb_q.l;
				offl = box_q.l + (rb_q.l - box_q.r);
			end
			fit = (offl >= lb_q.r);
		end
		if (!ln && !rn) newt = cmin(lb_q.b, rb_q.b);
		else if (ln)    newt = rb_q.b;
		else            newt = lb_q.b;

		ll   = ln ? box_q.l : cmax(box_q.l, lb_q.r);
		lr   = rn ? box_q.r : cmin(box_q.r, rb_q.l);
		lfit = ((lr - ll) >= $signed(CW'({1'b0, minw_q})));
		lt   = box_q.t;
		if (!ln) lt = cmax(lt, lb_q.b);
		if (!rn) lt = cmax(lt, rb_q.b);

		done   = (ln && rn) || (is_line ? lfit : fit);
		ev_box = box_q;
		if (is_line) begin
			if (done) begin
				ev_box.l = ll;
				ev_box.r = lr;
			end else begin
				ev_box.t = lt;
				ev_box.b = lt + CW'({1'b0, h_q});
			end
		end else if (!(ln && rn)) begin
			if (fit) begin
				ev_box.l = offl;
				ev_box.r = offr;
			end else begin
				ev_box.t = newt;
				ev_box.b = box_q.b + (newt - box_q.t);
			end
		end
	end

	// commit: result, store write, clearances
	rect16_t res16;
	logic    is_search, full_nx, wr_l, wr_r;
	logic [14:0] lc_nx, rc_nx;
	always_comb begin
		is_search = (mode_q <= MODE_LINE);
		res16.l   = is_search ? box_q.l[15:0] : '0;
		res16.t   = is_search ? box_q.t[15:0] : '0;
		res16.r   = is_search ? box_q.r[15:0] : '0;
		res16.b   = is_search ? box_q.b[15:0] : '0;
		full_nx   = 1'b0;
		wr_l      = 1'b0;
		wr_r      = 1'b0;
		lc_nx     = lc_q;
		rc_nx     = rc_q;
		case (mode_q)
			MODE_LEFT, MODE_SHRNK: begin
				if (left_cnt_q == CNT_W'(MAX_FLOATS)) full_nx = 1'b1;
				else wr_l = 1'b1;
			end
			MODE_RIGHT: begin
				if (right_cnt_q == CNT_W'(MAX_FLOATS)) full_nx = 1'b1;
				else wr_r = 1'b1;
			end
			MODE_CLEAR: begin
				lc_nx = '0;
				rc_nx = '0;
			end
			default: begin
			end
		endcase
		if (wr_l && mode_q == MODE_LEFT && $signed({1'b0, lc_q}) < res16.b) begin
			lc_nx = res16.b[14:0];
		end
		if ((wr_r || (wr_l && mode_q == MODE_SHRNK)) && $signed({1'b0, rc_q}) < res16.b) begin
			rc_nx = res16.b[14:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_cnt_q  <= '0;
			right_cnt_q <= '0;
			lc_q        <= '0;
			rc_q        <= '0;
			out_valid_q <= 1'b0;
			lval_s1     <= 1'b0;
			rval_s1     <= 1'b0;
		end else begin
			lval_s1 <= cmd.scan_step && (CNT_W'(cmd.idx) < left_cnt_q);
			rval_s1 <= cmd.scan_step && (CNT_W'(cmd.idx) < right_cnt_q);
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.commit) begin
				lc_q        <= lc_nx;
				rc_q        <= rc_nx;
				if (mode_q == MODE_CLEAR) begin
					left_cnt_q  <= '0;
					right_cnt_q <= '0;
				end
				if (wr_l) left_cnt_q <= left_cnt_q + 1'b1;
				if (wr_r) right_cnt_q <= right_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		lrd_s1 <= left_rects[cmd.idx];
		rrd_s1 <= right_rects[cmd.idx];
		if (cmd.commit && wr_l) left_rects[left_cnt_q[IDX_W-1:0]] <= res16;
		if (cmd.commit && wr_r) right_rects[right_cnt_q[IDX_W-1:0]] <= res16;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q   <= in_item.mode;
			box_q    <= ld_box;
			lim_q    <= ld_lim;
			h_q      <= in_item.line_height;
			minw_q   <= in_item.min_width;
			lb_q     <= '0;
			rb_q     <= '{l: ld_lim, t: '0, r: ld_lim, b: '0};
		end else if (cmd.eval) begin
			box_q <= ev_box;
			lb_q  <= '0;
			rb_q  <= '{l: lim_q, t: '0, r: lim_q, b: '0};
		end else begin
			if (l_take) lb_q <= lf;
			if (r_take) rb_q <= rf;
		end
		if (cmd.commit) begin
			out_item.out_left    <= res16.l;
			out_item.out_top     <= res16.t;
			out_item.out_right   <= res16.r;
			out_item.out_bottom  <= res16.b;
			out_item.left_clear  <= lc_nx;
			out_item.right_clear <= rc_nx;
			out_item.store_full  <= full_nx;
		end
	end

	assign out_valid          = out_valid_q;
	assign status.search_mode = (in_item.mode <= MODE_LINE);
	assign status.done        = done;
	assign status.out_free    = !out_valid_q || out_ready;

endmodule

@@ src/float_box_placement_table.sv @@
// Top level of the float box placement table: controller plus datapath.
// Depends on fbp_pkg, fbp_if, fbp_ctrl and fbp_dp.
//
//   channel   | role   | handshake   | moves
//   ----------+--------+-------------+-------------------------------------------
//   item_in   | sink   | valid/ready | mode, box edges, width, height, min width
//   item_out  | source | valid/ready | placed box, clearances, store_full flag
//
// Clear and unused modes go from idle straight to the done state. Placement and line
// search run passes that read one store entry per cycle, then drain and eval, at
// most 2 * MAX_FLOATS + 2 passes, between the idle and the done state.
// The single-read scan of the float stores sets the length of each pass.
// Reset clears counts, clearances and control; store contents stay as they are.
// A result waits in the output register; the next item is taken meanwhile and
// held at its end until the output register frees up.
module float_box_placement_table import fbp_pkg::*; (
	input logic clk,
	input logic arst_n,
	fbp_in_if.sink    item_in,
	fbp_out_if.source item_out
);

	ctl_cmd_t   cmd;
	dp_status_t status;
	in_item_t   in_item;
	out_item_t  out_item;
	logic       in_ready;
	logic       out_valid;

	// pack the input payload for the datapath
	always_comb begin
		in_item.mode            = item_in.mode;
		in_item.box_left        = item_in.box_left;
		in_item.box_top         = item_in.box_top;
		in_item.box_right       = item_in.box_right;
		in_item.box_bottom      = item_in.box_bottom;
		in_item.container_width = item_in.container_width;
		in_item.line_height     = item_in.line_height;
		in_item.min_width       = item_in.min_width;
	end

	assign item_in.ready = in_ready;

	fbp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item_in.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	fbp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.status    (status),
		.out_item  (out_item),
		.out_valid (out_valid),
		.out_ready (item_out.ready)
	);

	// drive the result channel from the output register
	assign item_out.valid       = out_valid;
	assign item_out.out_left    = out_item.out_left;
	assign item_out.out_top     = out_item.out_top;
	assign item_out.out_right   = out_item.out_right;
	assign item_out.out_bottom  = out_item.out_bottom;
	assign item_out.left_clear  = out_item.left_clear;
	assign item_out.right_clear = out_item.right_clear;
	assign item_out.store_full  = out_item.store_full;

	// an accepted item always keeps the block busy for the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_in.valid && item_in.ready |=> !item_in.ready)
		else $error("input taken right after an accepted item");

	// a new result appears only out of a busy phase
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(item_out.valid) |-> $past(!item_in.ready))
		else $error("result produced while idle");

	// a waiting result holds its fields until taken
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_out.valid && !item_out.ready |=> item_out.valid &&
		$stable({item_out.out_left, item_out.out_top, item_out.out_right,
			item_out.out_bottom, item_out.left_clear, item_out.right_clear,
			item_out.store_full}))
		else $error("waiting result changed");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for float_box_placement_table: random and directed items.
// Depends on fbp_pkg and the fbp_in_if / fbp_out_if interfaces from the RTL sources.
`timescale 1ns / 1ps

module tb_top;
	import fbp_pkg::*;

	localparam int CYCLE_LIMIT     = 6000000;
	localparam int PASS_LIMIT      = 2 * MAX_FLOATS + 2;
	localparam int HOLD_OFF_CYCLES = 400;

	// Mode codes the block leaves unused
	localparam logic [2:0] MODE_SPARE5 = 3'd5;
	localparam logic [2:0] MODE_SPARE6 = 3'd6;
	localparam logic [2:0] MODE_SPARE7 = 3'd7;

	typedef struct {
		int l;
		int t;
		int r;
		int b;
	} box_t;

	logic clk;
	logic arst_n;

	fbp_in_if  item_in();
	fbp_out_if item_out();

	float_box_placement_table uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_in (item_in),
		.item_out(item_out)
	);

	// Shadow copy of the float stores
	box_t   shadow_left[MAX_FLOATS];
	bit     left_is_right[MAX_FLOATS];
	int     left_used;
	box_t   shadow_right[MAX_FLOATS];
	int     right_used;

	out_item_t expected_results[$];
	int        mismatches = 0;
	int        cycle_count = 0;
	int        hold_requests = 0;
	bit        no_gaps;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Watchdog: a correct run stays far below this limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	function automatic int wrap16(int v);
		c16_t w;
		w = v[15:0];
		return int'(w);
	endfunction

	function automatic bit is_empty(box_t f);
		return f.l == f.r || f.t == f.b;
	endfunction

	function automatic bit overlaps_v(box_t f, box_t b);
		int lo;
		int hi;
		lo = (f.b < b.b) ? f.b : b.b;
		hi = (f.t > b.t) ? f.t : b.t;
		return lo > hi;
	endfunction

	// Left float with the greatest right edge that overlaps the box vertically
	function automatic box_t nearest_left(box_t b);
		box_t res;
		res = '{0, 0, 0, 0};
		for (int i = 0; i < left_used; i++)
			if (overlaps_v(shadow_left[i], b) && res.r < shadow_left[i].r)
				res = shadow_left[i];
		return res;
	endfunction

	// Right float with the least left edge, bounded by the limit
	function automatic box_t nearest_right(box_t b, int lim);
		box_t res;
		res = '{lim, 0, lim, 0};
		for (int i = 0; i < right_used; i++)
			if (overlaps_v(shadow_right[i], b) && res.l > shadow_right[i].l)
				res = shadow_right[i];
		return res;
	endfunction

	function automatic box_t place_box(box_t b, int lim, bit to_right);
		box_t lb;
		box_t rb;
		box_t moved;
		int   d;
		bit   ln;
		bit   rn;
		for (int n = 0; n < PASS_LIMIT; n++) begin
			lb = nearest_left(b);
			rb = nearest_right(b, lim);
			moved = b;
			ln = is_empty(lb);
			rn = is_empty(rb);
			if (ln && rn)
				break;
			if (!to_right) begin
				if (moved.l < lb.r) begin
					d = lb.r - moved.l;
					moved.l += d;
					moved.r += d;
				end
				if (moved.r <= rb.l)
					return moved;
			end else begin
				if (moved.r > rb.l) begin
					d = rb.l - moved.r;
					moved.l += d;
					moved.r += d;
				end
				if (moved.l >= lb.r)
					return moved;
			end
			if (!ln && !rn)
				d = ((lb.b < rb.b) ? lb.b : rb.b) - b.t;
			else if (ln)
				d = rb.b - b.t;
			else
				d = lb.b - b.t;
			b.t += d;
			b.b += d;
		end
		return b;
	endfunction

	function automatic box_t find_line(int left, int right, int y, int h, int minw);
		box_t b;
		box_t lb;
		box_t rb;
		bit   ln;
		bit   rn;
		b = '{left, y, right, y + h};
		for (int n = 0; n < PASS_LIMIT; n++) begin
			lb = nearest_left(b);
			rb = nearest_right(b, right);
			ln = is_empty(lb);
			rn = is_empty(rb);
			if (!ln && lb.r > b.l)
				b.l = lb.r;
			if (!rn && rb.l < b.r)
				b.r = rb.l;
			if (b.r - b.l >= minw || (ln && rn))
				return b;
			if (!ln && lb.b > b.t)
				b.t = lb.b;
			if (!rn && rb.b > b.t)
				b.t = rb.b;
			b.b = b.t + h;
			b.l = left;
			b.r = right;
		end
		return b;
	endfunction

	// Advance the shadow stores by one item and return the result it produces
	function automatic out_item_t predict_placement(in_item_t it);
		out_item_t o;
		box_t      b;
		box_t      res;
		int        lc;
		int        rc;
		bit        full;
		b = '{int'(it.box_left), int'(it.box_top), int'(it.box_right), int'(it.box_bottom)};
		res = '{0, 0, 0, 0};
		full = 1'b0;
		case (it.mode)
			MODE_LEFT, MODE_SHRNK: begin
				res = place_box(b, int'(it.container_width), 1'b0);
				res = '{wrap16(res.l), wrap16(res.t), wrap16(res.r), wrap16(res.b)};
				if (left_used >= MAX_FLOATS)
					full = 1'b1;
				else begin
					shadow_left[left_used] = res;
					left_is_right[left_used] = (it.mode == MODE_SHRNK);
					left_used++;
				end
			end
			MODE_RIGHT: begin
				res = place_box(b, int'(it.container_width), 1'b1);
				res = '{wrap16(res.l), wrap16(res.t), wrap16(res.r), wrap16(res.b)};
				if (right_used >= MAX_FLOATS)
					full = 1'b1;
				else begin
					shadow_right[right_used] = res;
					right_used++;
				end
			end
			MODE_LINE: begin
				res = find_line(b.l, b.r, b.t, int'(it.line_height), int'(it.min_width));
				res = '{wrap16(res.l), wrap16(res.t), wrap16(res.r), wrap16(res.b)};
			end
			MODE_CLEAR: begin
				left_used = 0;
				right_used = 0;
			end
			default: ;
		endcase
		lc = 0;
		rc = 0;
		for (int i = 0; i < left_used; i++) begin
			if (left_is_right[i])
				rc = (shadow_left[i].b > rc) ? shadow_left[i].b : rc;
			else
				lc = (shadow_left[i].b > lc) ? shadow_left[i].b : lc;
		end
		for (int i = 0; i < right_used; i++)
			rc = (shadow_right[i].b > rc) ? shadow_right[i].b : rc;
		o.out_left    = res.l[15:0];
		o.out_top     = res.t[15:0];
		o.out_right   = res.r[15:0];
		o.out_bottom  = res.b[15:0];
		o.left_clear  = lc[14:0];
		o.right_clear = rc[14:0];
		o.store_full  = full;
		return o;
	endfunction

	// Offer one item after a random gap and hold it until the block takes it
	task automatic send_item(in_item_t it);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			item_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_in.valid           <= 1'b1;
		item_in.mode            <= it.mode;
		item_in.box_left        <= it.box_left;
		item_in.box_top         <= it.box_top;
		item_in.box_right       <= it.box_right;
		item_in.box_bottom      <= it.box_bottom;
		item_in.container_width <= it.container_width;
		item_in.line_height     <= it.line_height;
		item_in.min_width       <= it.min_width;
		do @(posedge clk); while (!item_in.ready);
		expected_results.insert(expected_results.size(), predict_placement(it));
	endtask

	function automatic in_item_t mk_item(logic [2:0] m, int l, int t, int r, int b,
		int cw, int lh, int mw);
		in_item_t it;
		it.mode = m;
		it.box_left = l[15:0];
		it.box_top = t[15:0];
		it.box_right = r[15:0];
		it.box_bottom = b[15:0];
		it.container_width = cw[14:0];
		it.line_height = lh[14:0];
		it.min_width = mw[14:0];
		return it;
	endfunction

	function automatic in_item_t noise_item();
		in_item_t it;
		it.mode = 3'($urandom_range(0, 7));
		it.box_left = 16'($urandom);
		it.box_top = 16'($urandom);
		it.box_right = 16'($urandom);
		it.box_bottom = 16'($urandom);
		it.container_width = 15'($urandom);
		it.line_height = 15'($urandom);
		it.min_width = 15'($urandom);
		return it;
	endfunction

	// Well-formed float with small coordinates, so floats actually collide
	function automatic in_item_t layout_item(int cw);
		logic [2:0] m;
		int l;
		int t;
		int w;
		int h;
		m = 3'($urandom_range(0, 3));
		l = $urandom_range(0, 60);
		t = $urandom_range(0, 80);
		w = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 40);
		h = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 30);
		return mk_item(m, l, t, l + w, t + h, cw, $urandom_range(1, 30),
			$urandom_range(0, 100));
	endfunction

	// Result checker: compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		out_item_t want;
		out_item_t got;
		if (arst_n && item_out.valid && item_out.ready) begin
			got.out_left    = item_out.out_left;
			got.out_top     = item_out.out_top;
			got.out_right   = item_out.out_right;
			got.out_bottom  = item_out.out_bottom;
			got.left_clear  = item_out.left_clear;
			got.right_clear = item_out.right_clear;
			got.store_full  = item_out.store_full;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", got);
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %p actual %p", want, got);
				end
			end
		end
	end

	// Result receiver: random stalls, plus a long hold-off when requested
	initial begin
		int stall;
		int served;
		served = 0;
		item_out.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 3);
			if (hold_requests != served) begin
				served = hold_requests;
				item_out.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else if (stall > 0) begin
				item_out.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			item_out.ready <= 1'b1;
			do @(posedge clk); while (!(item_out.valid && item_out.ready));
		end
	end

	task automatic test_directed();
		send_item(mk_item(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk_item(MODE_LINE, 0, 0, 100, 0, 100, 10, 50));
		send_item(mk_item(MODE_LEFT, 0, 0, 30, 20, 100, 0, 0));
		send_item(mk_item(MODE_LEFT, 0, 5, 40, 25, 100, 0, 0));
		send_item(mk_item(MODE_RIGHT, 0, 0, 20, 30, 100, 0, 0));
		send_item(mk_item(MODE_SHRNK, 0, 0, 50, 10, 100, 0, 0));
		send_item(mk_item(MODE_LINE, 0, 0, 100, 0, 100, 10, 60));
		send_item(mk_item(MODE_LINE, 0, 0, 100, 0, 100, 0, 32767));
		// Zero-width and zero-height boxes are stored but never block
		send_item(mk_item(MODE_LEFT, 10, 10, 10, 40, 100, 0, 0));
		send_item(mk_item(MODE_RIGHT, 10, 10, 30, 10, 100, 0, 0));
		// Extremes of the coordinate fields; results wrap to 16 bits
		send_item(mk_item(MODE_LEFT, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
		send_item(mk_item(MODE_RIGHT, -32768, -32768, 32767, 32767, 32767, 0, 0));
		send_item(mk_item(MODE_LINE, -32768, -32768, 32767, 0, 0, 32767, 32767));
		send_item(mk_item(MODE_SPARE5, 1, 2, 3, 4, 5, 6, 7));
		send_item(mk_item(MODE_SPARE6, -1, -1, -1, -1, 32767, 32767, 32767));
		send_item(mk_item(MODE_SPARE7, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk_item(MODE_CLEAR, -1, -1, -1, -1, 32767, 32767, 32767));
		send_item(mk_item(MODE_LINE, 0, 0, 50, 0, 0, 5, 10));
	endtask

	// Fill both stores past capacity so the overflow flag rises
	task automatic test_store_overflow();
		send_item(mk_item(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0));
		for (int i = 0; i < MAX_FLOATS + 2; i++) begin
			send_item(mk_item((i % 2) ? MODE_SHRNK : MODE_LEFT, 0, i * 3, 5, i * 3 + 4,
				300, 0, 0));
			send_item(mk_item(MODE_RIGHT, 0, i * 3, 7, i * 3 + 4, 300, 0, 0));
		end
		send_item(mk_item(MODE_LINE, 0, 0, 300, 0, 300, 4, 290));
	endtask

	// Hold off the receiver so the block fills up and stalls its input
	task automatic test_back_pressure();
		send_item(mk_item(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0));
		hold_requests++;
		for (int i = 0; i < 12; i++)
			send_item(layout_item(150));
	endtask

	task automatic test_random_layouts(int n_items);
		int sent;
		int run;
		int cw;
		sent = 0;
		while (sent < n_items) begin
			// Some stretches with no idling on either side
			no_gaps = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 9) == 0) begin
				send_item(noise_item());
				sent++;
			end else begin
				send_item(mk_item(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0));
				run = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 40) :
					$urandom_range(1, 16);
				cw = $urandom_range(40, 200);
				for (int i = 0; i < run; i++)
					send_item(layout_item(cw));
				sent += run + 1;
			end
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		no_gaps = 1'b0;
		left_used = 0;
		right_used = 0;
		item_in.valid = 1'b0;
		item_in.mode = MODE_CLEAR;
		item_in.box_left = '0;
		item_in.box_top = '0;
		item_in.box_right = '0;
		item_in.box_bottom = '0;
		item_in.container_width = '0;
		item_in.line_height = '0;
		item_in.min_width = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_store_overflow();
		test_back_pressure();
		test_random_layouts(1350);

		item_in.valid <= 1'b0;
		wait (expected_results.size() == 0);
		repeat (50) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
